/* rtl/mqr_pkg.sv */
// ----------------------------------------------------------------------------
// mqr_pkg
// Shared types, sizes and codes for the message queue with reservations.
// ----------------------------------------------------------------------------
package mqr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ITEM_BITS   = 32;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int RES_W = 5;
  localparam int STAT_W = 32;

  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

  localparam logic [1:0] MODE_TASK_SEND = 2'd0;
  localparam logic [1:0] MODE_TASK_RECV = 2'd1;
  localparam logic [1:0] MODE_ISR_SEND  = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    OP_TASK_SEND,
    OP_TASK_RECV,
    OP_ISR_SEND,
    OP_MISUSE,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_REJECT,
    ST_BLOCK,
    ST_MISUSE
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    op_t                  op;
    logic [ITEM_BITS-1:0] data;
    logic                 holds;
    logic                 may_wait;
    logic                 woken;
  } cmd_t;

endpackage

/* rtl/mqr_ram.sv */
// ----------------------------------------------------------------------------
// mqr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mqr_front.sv */
// ----------------------------------------------------------------------------
// mqr_front
// Accepts request words, classifies them by mode and calling context, and
// holds them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module mqr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    mode,
  input  logic [31:0]                   item_data,
  input  logic                          holds_reservation,
  input  logic                          in_interrupt,
  input  logic                          may_wait,
  input  logic                          waiter_woken,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output mqr_pkg::cmd_t                 cmd
);

  mqr_pkg::cmd_t cq [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  mqr_pkg::cmd_t new_cmd;
  logic          do_push;
  logic          do_pop;

  always_comb begin
    new_cmd.data     = mqr_pkg::ITEM_BITS'(item_data);
    new_cmd.holds    = holds_reservation;
    new_cmd.may_wait = may_wait;
    new_cmd.woken    = waiter_woken;
    case (mode)
      mqr_pkg::MODE_TASK_SEND: begin
        new_cmd.op = in_interrupt ? mqr_pkg::OP_MISUSE : mqr_pkg::OP_TASK_SEND;
      end
      mqr_pkg::MODE_TASK_RECV: begin
        new_cmd.op = in_interrupt ? mqr_pkg::OP_MISUSE : mqr_pkg::OP_TASK_RECV;
      end
      mqr_pkg::MODE_ISR_SEND: begin
        new_cmd.op = in_interrupt ? mqr_pkg::OP_ISR_SEND : mqr_pkg::OP_MISUSE;
      end
      default: begin
        new_cmd.op = mqr_pkg::OP_NONE;
      end
    endcase
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = cq[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      cq[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("command queue fill out of range");

  a_ptr_fill: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("command queue pointers disagree with fill");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push && fill == 2'd1) |=> !cmd_valid)
    else $error("command queue did not drain");
`endif

endmodule

/* rtl/mqr_back.sv */
// ----------------------------------------------------------------------------
// mqr_back
// Executes queued commands against the ring buffer: space and data checks
// with reservations, index and count updates, interrupt and misuse statistics, and the
// result register seen by the consumer.
// ----------------------------------------------------------------------------
module mqr_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_wdata,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  mqr_pkg::cmd_t         cmd,
  output logic                  empty,
  input  logic                  pop,
  output logic [1:0]            status,
  output logic [31:0]           item_out,
  output logic [4:0]            occupancy,
  output logic                  switch_request,
  output logic [4:0]            high_water
);

  localparam int IW = mqr_pkg::IDX_W;
  localparam int CW = mqr_pkg::CNT_W;
  localparam int RW = mqr_pkg::RES_W;
  localparam int SW = mqr_pkg::STAT_W;

  mqr_pkg::bk_state_t state, state_next;

  logic [mqr_pkg::CAP_W-1:0] capacity, capacity_next;
  logic [IW-1:0] wr_idx, wr_idx_next;
  logic [IW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [RW-1:0] sres, sres_next;
  logic [RW-1:0] rres, rres_next;
  logic [CW-1:0] peak, peak_next;
  logic [SW-1:0] isr_att, isr_att_next;
  logic [SW-1:0] isr_acc, isr_acc_next;
  logic [SW-1:0] isr_drop, isr_drop_next;
  logic [SW-1:0] misuse, misuse_next;

  logic                    res_valid;
  mqr_pkg::status_t        res_status;
  logic [mqr_pkg::ITEM_BITS-1:0] res_item;
  logic [CW-1:0]           res_occ;
  logic                    res_sw;
  logic [CW-1:0]           res_hw;

  logic [CW-1:0]           cap;
  logic [CW:0]             cnt_plus_sres;
  logic                    space_base;
  logic                    space_task;
  logic                    space_isr;
  logic                    data_ok;
  logic [IW-1:0]           wr_inc;
  logic [IW-1:0]           rd_inc;
  logic                    take;
  logic                    ram_we;
  logic [mqr_pkg::ITEM_BITS-1:0] ram_rdata;
  mqr_pkg::status_t        st_val;
  logic                    sw_val;
  logic                    wait_read;

  function automatic logic [RW-1:0] sat_inc(input logic [RW-1:0] v);
    return (v == mqr_pkg::RES_MAX) ? v : v + RW'(1);
  endfunction

  function automatic logic [RW-1:0] sat_dec(input logic [RW-1:0] v);
    return (v == '0) ? v : v - RW'(1);
  endfunction

  assign cap = (32'(capacity) > mqr_pkg::QUEUE_DEPTH) ? CW'(mqr_pkg::QUEUE_DEPTH)
                                                       : CW'(capacity);
  assign cnt_plus_sres = (CW + 1)'(cnt) + (CW + 1)'(sres);
  assign space_base    = (cap != '0) && (cnt < cap);
  assign space_isr     = space_base && (cnt_plus_sres < (CW + 1)'(cap));
  assign space_task    = space_base && (cmd.holds || space_isr);
  assign data_ok       = (cnt != '0) && (cmd.holds || (32'(cnt) > 32'(rres)));
  assign wr_inc        = ((CW'(wr_idx) + CW'(1)) == cap) ? '0 : wr_idx + IW'(1);
  assign rd_inc        = ((CW'(rd_idx) + CW'(1)) == cap) ? '0 : rd_idx + IW'(1);

  assign cmd_ready = (state == mqr_pkg::BK_IDLE) && !res_valid;
  assign take      = cmd_valid && cmd_ready;

  mqr_ram #(
    .WIDTH (mqr_pkg::ITEM_BITS),
    .DEPTH (mqr_pkg::QUEUE_DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx),
    .wdata (cmd.data),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next    = state;
    capacity_next = capacity;
    wr_idx_next   = wr_idx;
    rd_idx_next   = rd_idx;
    cnt_next      = cnt;
    sres_next     = sres;
    rres_next     = rres;
    peak_next     = peak;
    isr_att_next  = isr_att;
    isr_acc_next  = isr_acc;
    isr_drop_next = isr_drop;
    misuse_next   = misuse;
    ram_we        = 1'b0;
    st_val        = mqr_pkg::ST_REJECT;
    sw_val        = 1'b0;
    wait_read     = 1'b0;

    case (state)
      mqr_pkg::BK_IDLE: begin
        if (take) begin
          case (cmd.op)
            mqr_pkg::OP_TASK_SEND: begin
              if (space_task) begin
                ram_we      = 1'b1;
                wr_idx_next = wr_inc;
                cnt_next    = cnt + CW'(1);
                if (cmd.holds) begin
                  sres_next = sat_dec(sres);
                end
                if (cmd.woken) begin
                  rres_next = sat_inc(rres);
                end
                st_val = mqr_pkg::ST_DONE;
              end else begin
                st_val = cmd.may_wait ? mqr_pkg::ST_BLOCK : mqr_pkg::ST_REJECT;
              end
            end
            mqr_pkg::OP_TASK_RECV: begin
              if (data_ok) begin
                rd_idx_next = (cap != '0) ? rd_inc : '0;
                cnt_next    = cnt - CW'(1);
                if (cmd.holds) begin
                  rres_next = sat_dec(rres);
                end
                if (cmd.woken) begin
                  sres_next = sat_inc(sres);
                end
                st_val     = mqr_pkg::ST_DONE;
                wait_read  = 1'b1;
                state_next = mqr_pkg::BK_READ;
              end else begin
                st_val = cmd.may_wait ? mqr_pkg::ST_BLOCK : mqr_pkg::ST_REJECT;
              end
            end
            mqr_pkg::OP_ISR_SEND: begin
              isr_att_next = isr_att + SW'(1);
              if (space_isr) begin
                ram_we       = 1'b1;
                wr_idx_next  = wr_inc;
                cnt_next     = cnt + CW'(1);
                isr_acc_next = isr_acc + SW'(1);
                if (cnt_next > peak) begin
                  peak_next = cnt_next;
                end
                if (cmd.woken) begin
                  rres_next = sat_inc(rres);
                end
                sw_val = 1'b1;
                st_val = mqr_pkg::ST_DONE;
              end else begin
                isr_drop_next = isr_drop + SW'(1);
                st_val        = mqr_pkg::ST_REJECT;
              end
            end
            mqr_pkg::OP_MISUSE: begin
              misuse_next = misuse + SW'(1);
              st_val      = mqr_pkg::ST_MISUSE;
            end
            default: begin
              st_val = mqr_pkg::ST_REJECT;
            end
          endcase
        end
      end
      mqr_pkg::BK_READ: begin
        state_next = mqr_pkg::BK_IDLE;
      end
      default: begin
        state_next = mqr_pkg::BK_IDLE;
      end
    endcase

    if (cfg_we) begin
      capacity_next = cfg_wdata;
      wr_idx_next   = '0;
      rd_idx_next   = '0;
      cnt_next      = '0;
      sres_next     = '0;
      rres_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mqr_pkg::BK_IDLE;
      capacity  <= mqr_pkg::CAP_RESET;
      wr_idx    <= '0;
      rd_idx    <= '0;
      cnt       <= '0;
      sres      <= '0;
      rres      <= '0;
      peak      <= '0;
      isr_att   <= '0;
      isr_acc   <= '0;
      isr_drop  <= '0;
      misuse    <= '0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      capacity <= capacity_next;
      wr_idx   <= wr_idx_next;
      rd_idx   <= rd_idx_next;
      cnt      <= cnt_next;
      sres     <= sres_next;
      rres     <= rres_next;
      peak     <= peak_next;
      isr_att  <= isr_att_next;
      isr_acc  <= isr_acc_next;
      isr_drop <= isr_drop_next;
      misuse   <= misuse_next;
      if (take) begin
        res_valid <= !wait_read;
      end else if (state == mqr_pkg::BK_READ) begin
        res_valid <= 1'b1;
      end else if (pop && res_valid) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_status <= st_val;
      res_item   <= '0;
      res_occ    <= cnt_next;
      res_sw     <= sw_val;
      res_hw     <= peak_next;
    end else if (state == mqr_pkg::BK_READ) begin
      res_item <= ram_rdata;
    end
  end

  assign empty          = !res_valid;
  assign status         = res_status;
  assign item_out       = 32'(res_item);
  assign occupancy      = 5'(res_occ);
  assign switch_request = res_sw;
  assign high_water     = 5'(res_hw);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= cap || cnt == '0)
    else $error("item count above capacity");

  a_read_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == mqr_pkg::BK_READ) |-> !res_valid)
    else $error("result present while slot read pending");

  a_take_yields: assert property (@(posedge clk) disable iff (rst)
    take |=> (res_valid || state == mqr_pkg::BK_READ))
    else $error("command taken without result");

  a_wr_idx_range: assert property (@(posedge clk) disable iff (rst)
    (CW'(wr_idx) < cap) || (wr_idx == '0))
    else $error("write index outside capacity");

  a_peak_tracks: assert property (@(posedge clk) disable iff (rst)
    (take && cmd.op == mqr_pkg::OP_ISR_SEND && sw_val) |=> (peak >= cnt))
    else $error("high water below occupancy after interrupt send");
`endif

endmodule

/* rtl/message_queue_with_reservations_top.sv */
// ----------------------------------------------------------------------------
// message_queue_with_reservations_top
// Ring-buffer message queue with send and receive reservations.
// ----------------------------------------------------------------------------
// Requests enter through a two-word command queue, so push is taken while a
// result is still waiting to be popped. The execute stage handles one request
// at a time and takes the next command only once the previous result has been
// popped: sends, rejects and misuse answers go straight to the result register
// when the command is taken, while a successful receive first passes through
// the read state because the slot RAM has a registered read port; each command
// is also registered in the command queue before it is taken. Writing the
// capacity through cfg_we empties the queue and keeps the statistics; write it
// only while no request is pending.
// ----------------------------------------------------------------------------
module message_queue_with_reservations_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [31:0] item_data,
  input  logic        holds_reservation,
  input  logic        in_interrupt,
  input  logic        may_wait,
  input  logic        waiter_woken,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic [31:0] item_out,
  output logic [4:0]  occupancy,
  output logic        switch_request,
  output logic [4:0]  high_water
);

  logic          cmd_valid;
  logic          cmd_ready;
  mqr_pkg::cmd_t cmd;

  mqr_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .mode              (mode),
    .item_data         (item_data),
    .holds_reservation (holds_reservation),
    .in_interrupt      (in_interrupt),
    .may_wait          (may_wait),
    .waiter_woken      (waiter_woken),
    .cmd_valid         (cmd_valid),
    .cmd_ready         (cmd_ready),
    .cmd               (cmd)
  );

  mqr_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .item_out       (item_out),
    .occupancy      (occupancy),
    .switch_request (switch_request),
    .high_water     (high_water)
  );

endmodule
